FILE: src/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and defaults for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int OP_W           = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_t;

endpackage

FILE: src/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Signed fixed point complex add, subtract, multiply, divide and modulus,
// with saturation, overflow and divide-by-zero flags.
//
//   channel | direction | handshake            | payload
//   in_     | in        | in_valid / in_stall  | operation, a_re, a_im, b_re, b_im
//   out_    | out       | out_valid / out_stall| result_re, result_im, overflow,
//           |           |                      | divide_by_zero
//
// One request per cycle enters while in_stall is low; each passes the product,
// sum and setup stages, the DATA_WIDTH + 2 stage bit-per-stage divider chain
// and the result stage before out_valid.
// Synchronous active-low reset clears the stage valid bits only.
// Stalls compress bubbles: a stage advances when the one after it is empty
// or advancing, so in_stall rises only while the result stage is full and held.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cau_pkg::OP_W-1:0]      in_operation,
  input  logic signed [DATA_WIDTH-1:0]  in_a_re,
  input  logic signed [DATA_WIDTH-1:0]  in_a_im,
  input  logic signed [DATA_WIDTH-1:0]  in_b_re,
  input  logic signed [DATA_WIDTH-1:0]  in_b_im,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  out_result_re,
  output logic signed [DATA_WIDTH-1:0]  out_result_im,
  output logic                          out_overflow,
  output logic                          out_divide_by_zero
);
  import cau_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int SW  = PW + 1;
  localparam int MW  = PW + 1;
  localparam int QB  = W + 2;
  localparam int RW  = PW + QB;
  localparam int SRW = PW + 1;
  localparam int CW  = PW + ((F + 1 > QB) ? F + 1 : QB);
  localparam int L   = QB;
  localparam int NS  = L + 4;

  localparam logic [MW-1:0] HALF    = (MW'(1) << F) >> 1;
  localparam logic [W-1:0]  POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  NEG_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [MW-1:0] NEG_LIM = MW'(1) << (W - 1);

  typedef struct packed {
    op_t             op;
    logic            dz;
    logic            neg_re;
    logic            neg_im;
    logic [MW-1:0]   mag_re;
    logic [MW-1:0]   mag_im;
    logic            dov_re;
    logic            dov_im;
    logic [RW-1:0]   rem_re;
    logic [RW-1:0]   rem_im;
    logic [QB-1:0]   q_re;
    logic [QB-1:0]   q_im;
    logic [PW-1:0]   den;
    logic [PW-1:0]   sqn;
    logic [SRW-1:0]  sres;
  } item_t;

  function automatic logic [W:0] sat_f(input logic neg, input logic big,
                                       input logic [MW-1:0] mag);
    logic [W:0] r;
    if (!neg) begin
      if (big || mag > MW'(POS_MAX)) r = {1'b1, POS_MAX};
      else                           r = {1'b0, mag[W-1:0]};
    end else begin
      if (big || mag > NEG_LIM) r = {1'b1, NEG_MIN};
      else                      r = {1'b0, W'(-mag)};
    end
    return r;
  endfunction

  // stage control
  logic [NS-1:0] vld_r, vld_nxt, adv;

  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt = (adv & {vld_r[NS-2:0], in_valid}) | (~adv & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NS-1];

  // stage 1: add/subtract and products
  op_t                   op1_r;
  logic signed [W:0]     as_re1_r, as_im1_r;
  logic signed [PW-1:0]  p_rr1_r, p_ii1_r, p_ri1_r, p_ir1_r, sq01_r, sq11_r;
  logic signed [W-1:0]   sq_x, sq_y;

  always_comb begin
    sq_x = (in_operation == OP_MOD) ? in_a_re : in_b_re;
    sq_y = (in_operation == OP_MOD) ? in_a_im : in_b_im;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      op1_r <= op_t'(in_operation);
      if (in_operation == OP_SUB) begin
        as_re1_r <= (W+1)'(in_a_re) - (W+1)'(in_b_re);
        as_im1_r <= (W+1)'(in_a_im) - (W+1)'(in_b_im);
      end else begin
        as_re1_r <= (W+1)'(in_a_re) + (W+1)'(in_b_re);
        as_im1_r <= (W+1)'(in_a_im) + (W+1)'(in_b_im);
      end
      p_rr1_r <= in_a_re * in_b_re;
      p_ii1_r <= in_a_im * in_b_im;
      p_ri1_r <= in_a_re * in_b_im;
      p_ir1_r <= in_a_im * in_b_re;
      sq01_r  <= sq_x * sq_x;
      sq11_r  <= sq_y * sq_y;
    end
  end

  // stage 2: sums
  op_t                  op2_r;
  logic signed [SW-1:0] s2_re_r, s2_im_r, s2_re_nxt, s2_im_nxt;
  logic [PW-1:0]        s2_sq_r;

  always_comb begin
    case (op1_r)
      OP_ADD, OP_SUB: begin
        s2_re_nxt = SW'(as_re1_r);
        s2_im_nxt = SW'(as_im1_r);
      end
      OP_MUL: begin
        s2_re_nxt = SW'(p_rr1_r) - SW'(p_ii1_r);
        s2_im_nxt = SW'(p_ri1_r) + SW'(p_ir1_r);
      end
      OP_DIV: begin
        s2_re_nxt = SW'(p_rr1_r) + SW'(p_ii1_r);
        s2_im_nxt = SW'(p_ir1_r) - SW'(p_ri1_r);
      end
      default: begin
        s2_re_nxt = '0;
        s2_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      op2_r   <= op1_r;
      s2_re_r <= s2_re_nxt;
      s2_im_r <= s2_im_nxt;
      s2_sq_r <= $unsigned(sq01_r) + $unsigned(sq11_r);
    end
  end

  // stage 3: magnitudes, rounding, divider setup
  item_t         ch_r [L+1];
  item_t         ch_nxt [L];
  item_t         prep;
  logic [MW-1:0] abs_re, abs_im, rnd_re, rnd_im;

  always_comb begin
    abs_re = s2_re_r[SW-1] ? MW'(-s2_re_r) : MW'(s2_re_r);
    abs_im = s2_im_r[SW-1] ? MW'(-s2_im_r) : MW'(s2_im_r);
    rnd_re = (abs_re + HALF) >> F;
    rnd_im = (abs_im + HALF) >> F;
    prep        = '0;
    prep.op     = op2_r;
    prep.den    = s2_sq_r;
    prep.sqn    = s2_sq_r;
    prep.neg_re = s2_re_r[SW-1];
    prep.neg_im = s2_im_r[SW-1];
    case (op2_r)
      OP_ADD, OP_SUB: begin
        prep.mag_re = abs_re;
        prep.mag_im = abs_im;
      end
      OP_MUL: begin
        prep.mag_re = rnd_re;
        prep.mag_im = rnd_im;
        prep.neg_re = s2_re_r[SW-1] && (rnd_re != '0);
        prep.neg_im = s2_im_r[SW-1] && (rnd_im != '0);
      end
      OP_DIV: begin
        prep.dz     = (s2_sq_r == '0);
        prep.rem_re = RW'(abs_re) << (F + 1);
        prep.rem_im = RW'(abs_im) << (F + 1);
        prep.dov_re = (CW'(abs_re) << (F + 1)) >= (CW'(s2_sq_r) << QB);
        prep.dov_im = (CW'(abs_im) << (F + 1)) >= (CW'(s2_sq_r) << QB);
      end
      default: begin
        prep.neg_re = 1'b0;
        prep.neg_im = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[2]) ch_r[0] <= prep;
  end

  // divider and square root, one quotient / root bit per stage
  for (genvar k = 0; k < L; k++) begin : g_step
    localparam int  QI    = L - 1 - k;
    localparam bit  SQ_ON = (k < W);
    localparam int  SB    = (k < W) ? 2 * (W - 1 - k) : 0;
    item_t          st;
    logic [RW-1:0]  dsh;
    logic [SRW-1:0] sbit, stry;

    always_comb begin
      st   = ch_r[k];
      dsh  = RW'(st.den) << QI;
      sbit = SRW'(1) << SB;
      stry = st.sres + sbit;
      if (st.rem_re >= dsh) begin
        st.rem_re   = st.rem_re - dsh;
        st.q_re[QI] = 1'b1;
      end
      if (st.rem_im >= dsh) begin
        st.rem_im   = st.rem_im - dsh;
        st.q_im[QI] = 1'b1;
      end
      if (SQ_ON) begin
        if (SRW'(st.sqn) >= stry) begin
          st.sqn  = st.sqn - PW'(stry);
          st.sres = (st.sres >> 1) + sbit;
        end else begin
          st.sres = st.sres >> 1;
        end
      end
      ch_nxt[k] = st;
    end

    always_ff @(posedge clk) begin
      if (adv[k+3]) ch_r[k+1] <= ch_nxt[k];
    end
  end

  // final rounding and saturation
  item_t          fin;
  logic [MW-1:0]  dmag_re, dmag_im, smag;
  logic [SRW-1:0] sroot;
  logic [W:0]     sat_re, sat_im;
  logic [W-1:0]   res_re_nxt, res_im_nxt;
  logic           ovf_nxt, dz_nxt;

  always_comb begin
    fin     = ch_r[L];
    dmag_re = MW'(((QB+1)'(fin.q_re) + (QB+1)'(1)) >> 1);
    dmag_im = MW'(((QB+1)'(fin.q_im) + (QB+1)'(1)) >> 1);
    sroot   = fin.sres + SRW'(SRW'(fin.sqn) > fin.sres);
    smag    = MW'(sroot);
    sat_re  = '0;
    sat_im  = '0;
    dz_nxt  = 1'b0;
    case (fin.op)
      OP_ADD, OP_SUB, OP_MUL: begin
        sat_re = sat_f(fin.neg_re, 1'b0, fin.mag_re);
        sat_im = sat_f(fin.neg_im, 1'b0, fin.mag_im);
      end
      OP_DIV: begin
        if (fin.dz) begin
          dz_nxt = 1'b1;
        end else begin
          sat_re = sat_f(fin.neg_re, fin.dov_re, dmag_re);
          sat_im = sat_f(fin.neg_im, fin.dov_im, dmag_im);
        end
      end
      OP_MOD: begin
        sat_re = sat_f(1'b0, 1'b0, smag);
      end
      default: begin
        sat_re = '0;
      end
    endcase
    res_re_nxt = sat_re[W-1:0];
    res_im_nxt = sat_im[W-1:0];
    ovf_nxt    = sat_re[W] || sat_im[W];
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      out_result_re      <= res_re_nxt;
      out_result_im      <= res_im_nxt;
      out_overflow       <= ovf_nxt;
      out_divide_by_zero <= dz_nxt;
    end
  end

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |->
      out_result_re == '0 && out_result_im == '0 && !out_overflow)
    else $error("divide-by-zero result not cleared");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input held without a held result");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-2] && !adv[NS-2] |=> vld_r[NS-2])
    else $error("held request dropped before result stage");
`endif

endmodule

FILE: tb/tb_complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Drives complex operand requests into the unit and checks every result
// against a fixed point predictor kept in the bench. Directed corner cases
// come first, then random requests under three sender/receiver idle mixes,
// a long receiver hold and a full drain pause.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int W          = DATA_WIDTH_DEF;
  localparam int FB         = FRAC_BITS_DEF;
  localparam int HOLD_LEN   = 300;
  localparam int TAIL       = 40;
  localparam int PAUSE_AT   = 200;
  localparam int MAX_CYCLES = 400000;
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_W'(OP_MOD + 1);
  localparam logic [OP_W-1:0] OP_LAST_CODE    = '1;
  localparam longint VMAX = (longint'(1) <<< (W - 1)) - 1;
  localparam longint VMIN = -(longint'(1) <<< (W - 1));

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic signed [W-1:0] a_re, a_im, b_re, b_im;
  } request_t;

  typedef struct packed {
    logic signed [W-1:0] re, im;
    logic                ovf, dz;
  } answer_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [OP_W-1:0] in_operation;
  logic signed [W-1:0] in_a_re, in_a_im, in_b_re, in_b_im;
  logic signed [W-1:0] out_result_re, out_result_im;
  logic out_overflow, out_divide_by_zero;

  request_t pending[$];
  answer_t  awaited[$];
  int  errors = 0;
  int  cycles = 0;
  int  idle_pct = 0, stall_pct = 0;
  bit  sender_pause = 0;
  int  hold_req = 0, hold_seen = 0, hold_cnt = 0;

  complex_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_a_re(in_a_re), .in_a_im(in_a_im), .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_re(out_result_re), .out_result_im(out_result_im),
    .out_overflow(out_overflow), .out_divide_by_zero(out_divide_by_zero)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [W-1:0] clip(longint v, inout logic ovf);
    if (v > VMAX) begin
      ovf = 1;
      return W'(VMAX);
    end
    if (v < VMIN) begin
      ovf = 1;
      return W'(VMIN);
    end
    return W'(v);
  endfunction

  function automatic longint round_frac(longint v);
    longint m;
    m = ((v < 0 ? -v : v) + ((longint'(1) <<< FB) >>> 1)) >>> FB;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint div_round(longint n, longint den);
    longint q;
    q = (((n < 0 ? -n : n) <<< (FB + 1)) / den + 1) >>> 1;
    return n < 0 ? -q : q;
  endfunction

  function automatic longint sqrt_round(longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = longint'(1) <<< 32;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    if (n - lo * lo > lo) lo++;
    return lo;
  endfunction

  function automatic answer_t complex_result(request_t r);
    longint ar, ai, br, bi, re, im, den;
    answer_t ans;
    ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
    re = 0; im = 0;
    ans = '0;
    case (r.op)
      OP_ADD: begin re = ar + br; im = ai + bi; end
      OP_SUB: begin re = ar - br; im = ai - bi; end
      OP_MUL: begin
        re = round_frac(ar * br - ai * bi);
        im = round_frac(ar * bi + ai * br);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) ans.dz = 1;
        else begin
          re = div_round(ar * br + ai * bi, den);
          im = div_round(ai * br - ar * bi, den);
        end
      end
      OP_MOD: re = sqrt_round(ar * ar + ai * ai);
      default: ;
    endcase
    ans.re = clip(re, ans.ovf);
    ans.im = clip(im, ans.ovf);
    return ans;
  endfunction

  function automatic logic signed [W-1:0] rand_val();
    case ($urandom_range(5))
      0: return W'(VMAX - $urandom_range(3));
      1: return W'(VMIN + $urandom_range(3));
      2: return W'($signed($urandom_range(2047)) - 1024);
      3: return '0;
      default: return W'($urandom);
    endcase
  endfunction

  function automatic request_t rand_request();
    request_t r;
    r.op   = OP_W'(($urandom_range(19) == 0)
                   ? $urandom_range(OP_LAST_CODE, OP_FIRST_UNUSED)
                   : $urandom_range(OP_MOD, OP_ADD));
    r.a_re = rand_val();
    r.a_im = rand_val();
    r.b_re = rand_val();
    r.b_im = rand_val();
    if (r.op == OP_DIV && $urandom_range(7) == 0) begin
      r.b_re = '0;
      r.b_im = '0;
    end
    return r;
  endfunction

  task automatic add_request(logic [OP_W-1:0] op, longint ar, longint ai,
                             longint br, longint bi);
    request_t r;
    r.op = op; r.a_re = W'(ar); r.a_im = W'(ai); r.b_re = W'(br); r.b_im = W'(bi);
    pending.push_back(r);
  endtask

  task automatic add_random(int n);
    repeat (n) pending.push_back(rand_request());
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_valid || awaited.size() != 0) @(posedge clk);
  endtask

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_operation <= '0;
      in_a_re <= '0; in_a_im <= '0; in_b_re <= '0; in_b_im <= '0;
    end else begin
      if (in_valid && !in_stall)
        awaited.push_back(complex_result({in_operation, in_a_re, in_a_im,
                                          in_b_re, in_b_im}));
      if (!in_valid || !in_stall) begin
        if (sender_pause || pending.size() == 0 || $urandom_range(99) < idle_pct)
          in_valid <= 0;
        else begin
          request_t r;
          r = pending.pop_front();
          in_valid <= 1;
          in_operation <= r.op;
          in_a_re <= r.a_re; in_a_im <= r.a_im; in_b_re <= r.b_re; in_b_im <= r.b_im;
        end
      end
    end
  end

  // receiver stall, with a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= HOLD_LEN;
      out_stall <= 1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        answer_t e;
        e = awaited.pop_front();
        if (out_result_re !== e.re) report("result_re", out_result_re, e.re);
        if (out_result_im !== e.im) report("result_im", out_result_im, e.im);
        if (out_overflow !== e.ovf) report("overflow", out_overflow, e.ovf);
        if (out_divide_by_zero !== e.dz)
          report("divide_by_zero", out_divide_by_zero, e.dz);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    idle_pct = 8;
    stall_pct = 86;
    add_request(OP_ADD, VMAX, VMAX, VMAX, VMAX);
    add_request(OP_ADD, VMIN, 0, VMIN, 5);
    add_request(OP_ADD, 1, -1, -1, 1);
    add_request(OP_SUB, VMIN, VMAX, VMAX, VMIN);
    add_request(OP_SUB, 0, 0, VMIN, 0);
    add_request(OP_MUL, VMIN, VMIN, VMIN, VMIN);
    add_request(OP_MUL, VMIN, 0, VMIN, 0);
    add_request(OP_MUL, 128, 0, 1, 0);
    add_request(OP_MUL, -128, 0, 1, 0);
    add_request(OP_MUL, 256, 256, 256, -256);
    add_request(OP_DIV, 256, 0, 0, 0);
    add_request(OP_DIV, VMAX, VMIN, 0, 0);
    add_request(OP_DIV, VMAX, VMIN, 1, 0);
    add_request(OP_DIV, 256, 256, 256, 256);
    add_request(OP_DIV, -1, 1, VMIN, VMAX);
    add_request(OP_MOD, VMIN, VMIN, 7, 7);
    add_request(OP_MOD, 0, 0, 0, 0);
    add_request(OP_MOD, 3, 4, 0, 0);
    add_request(OP_MOD, VMAX, 0, 0, 0);
    add_request(OP_FIRST_UNUSED, VMAX, VMIN, 1, 1);
    add_request(OP_W'(OP_FIRST_UNUSED + 1), -1, -1, -1, -1);
    add_request(OP_LAST_CODE, 100, 200, 0, 0);
    drain();
    add_random(170);

    hold_req = hold_req + 1;
    drain();

    idle_pct = 86;
    stall_pct = 8;
    add_random(165);
    repeat (PAUSE_AT) @(posedge clk);
    sender_pause = 1;
    while (in_valid || awaited.size() != 0) @(posedge clk);
    sender_pause = 0;
    drain();

    idle_pct = 0;
    stall_pct = 0;
    add_random(165);
    drain();

    repeat (TAIL) @(posedge clk);
    if (errors == 0 && awaited.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
